@@ src/sec_pkg.sv @@
`timescale 1ns / 1ps

package sec_pkg;

   // Longest keypad entry, in decimal digits (1 to 4).
   localparam int MAX_DIGITS = 4;

   localparam int VALUE_W = 14;
   localparam int STEP_W  = 10;
   localparam int KEY_W   = 5;
   localparam int STAT_W  = 3;
   localparam int DAC_W   = 12;
   localparam int LEFT_W  = 3;

   // Event status codes.
   localparam logic [STAT_W-1:0] ST_NONE   = 3'd0;
   localparam logic [STAT_W-1:0] ST_DIGIT  = 3'd1;
   localparam logic [STAT_W-1:0] ST_ACCEPT = 3'd2;
   localparam logic [STAT_W-1:0] ST_ABORT  = 3'd3;
   localparam logic [STAT_W-1:0] ST_UPPER  = 3'd4;
   localparam logic [STAT_W-1:0] ST_LOWER  = 3'd5;

   // Function keys.
   localparam logic [KEY_W-1:0] KEY_SEL_CH1_VOLT = 5'd1;
   localparam logic [KEY_W-1:0] KEY_SEL_CH1_AMP  = 5'd5;
   localparam logic [KEY_W-1:0] KEY_SEL_CH2_VOLT = 5'd9;
   localparam logic [KEY_W-1:0] KEY_SEL_CH2_AMP  = 5'd13;
   localparam logic [KEY_W-1:0] KEY_OUTPUT       = 5'd16;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_VOLT_UPPER = 3'd0;
   localparam logic [2:0] REG_VOLT_LOWER = 3'd1;
   localparam logic [2:0] REG_VOLT_STEP  = 3'd2;
   localparam logic [2:0] REG_AMP_UPPER  = 3'd3;
   localparam logic [2:0] REG_AMP_LOWER  = 3'd4;
   localparam logic [2:0] REG_AMP_STEP   = 3'd5;

   localparam logic [VALUE_W-1:0] VOLT_UPPER_RESET = 14'd200;
   localparam logic [VALUE_W-1:0] VOLT_LOWER_RESET = 14'd5;
   localparam logic [STEP_W-1:0]  VOLT_STEP_RESET  = 10'd1;
   localparam logic [VALUE_W-1:0] AMP_UPPER_RESET  = 14'd3000;
   localparam logic [VALUE_W-1:0] AMP_LOWER_RESET  = 14'd0;
   localparam logic [STEP_W-1:0]  AMP_STEP_RESET   = 10'd10;

   localparam logic [VALUE_W-1:0] VOLT_SETPOINT_RESET = 14'd5;
   localparam logic [VALUE_W-1:0] AMP_SETPOINT_RESET  = 14'd10;

   // DAC code is floor(v * 2814 / 200) + 21, saturated at 4095. Codes from
   // v = 290 upward saturate, so only 9 bits of v reach the multiplier, and
   // floor(v * 14.07) is exact there as (v * ceil(14.07 * 2^16)) >> 16.
   localparam int DAC_SAT_FROM = 290;
   localparam int DAC_V_W      = 9;
   localparam int DAC_FRAC     = 16;
   localparam int DAC_MULT     = 922092;
   localparam int DAC_MULT_W   = 20;
   localparam int DAC_PROD_W   = DAC_V_W + DAC_MULT_W;
   localparam int DAC_OFFSET   = 21;
   localparam logic [DAC_W-1:0] DAC_MAX = 12'd4095;

   typedef struct packed {
      logic [VALUE_W-1:0] volt_upper;
      logic [VALUE_W-1:0] volt_lower;
      logic [STEP_W-1:0]  volt_step;
      logic [VALUE_W-1:0] amp_upper;
      logic [VALUE_W-1:0] amp_lower;
      logic [STEP_W-1:0]  amp_step;
   } cfg_type;

   typedef struct packed {
      logic [3:0][VALUE_W-1:0] setpoints;
      logic [1:0]              selection;
      logic                    enable_flag;
      logic                    entering;
      logic [VALUE_W-1:0]      partial_number;
      logic [LEFT_W-1:0]       digits_left;
   } state_type;

   typedef struct packed {
      logic             func;
      logic             enc_up;
      logic [KEY_W-1:0] key_code;
   } item_type;

   // Result fields apart from the DAC code, which is added one stage later.
   typedef struct packed {
      logic [1:0]              selected_index;
      logic [3:0][VALUE_W-1:0] setpoints;
      logic                    entry_active;
      logic [VALUE_W-1:0]      entry_number;
      logic [STAT_W-1:0]       event_status;
      logic                    output_on;
   } view_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] value;
   } digit_type;

   function automatic digit_type key_digit(logic [KEY_W-1:0] key);
      digit_type d;
      d.hit = 1'b1;
      case (key)
         5'd2:    d.value = 4'd7;
         5'd3:    d.value = 4'd8;
         5'd4:    d.value = 4'd9;
         5'd6:    d.value = 4'd4;
         5'd7:    d.value = 4'd5;
         5'd8:    d.value = 4'd6;
         5'd10:   d.value = 4'd1;
         5'd11:   d.value = 4'd2;
         5'd12:   d.value = 4'd3;
         5'd15:   d.value = 4'd0;
         default: begin
            d.hit   = 1'b0;
            d.value = 4'd0;
         end
      endcase
      return d;
   endfunction

   // Decimal digit count of the upper limit, at least one, at most MAX_DIGITS.
   function automatic logic [LEFT_W-1:0] entry_len(logic [VALUE_W-1:0] upper);
      logic [LEFT_W-1:0] n;
      n = LEFT_W'(1);
      for (int i = 1; i < MAX_DIGITS; i++) begin
         if (upper >= VALUE_W'(10 ** i)) begin
            n = n + LEFT_W'(1);
         end
      end
      return n;
   endfunction

endpackage

@@ src/sec_csr.sv @@
`timescale 1ns / 1ps

module sec_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output sec_pkg::cfg_type   cfg
);

   sec_pkg::cfg_type cfg_ff;
   sec_pkg::cfg_type cfg_in;
   logic [2:0]       index;
   logic             write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[4:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            sec_pkg::REG_VOLT_UPPER: cfg_in.volt_upper = csr_pwdata[13:0];
            sec_pkg::REG_VOLT_LOWER: cfg_in.volt_lower = csr_pwdata[13:0];
            sec_pkg::REG_VOLT_STEP:  cfg_in.volt_step  = csr_pwdata[9:0];
            sec_pkg::REG_AMP_UPPER:  cfg_in.amp_upper  = csr_pwdata[13:0];
            sec_pkg::REG_AMP_LOWER:  cfg_in.amp_lower  = csr_pwdata[13:0];
            sec_pkg::REG_AMP_STEP:   cfg_in.amp_step   = csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         sec_pkg::REG_VOLT_UPPER: csr_prdata = {18'd0, cfg_ff.volt_upper};
         sec_pkg::REG_VOLT_LOWER: csr_prdata = {18'd0, cfg_ff.volt_lower};
         sec_pkg::REG_VOLT_STEP:  csr_prdata = {22'd0, cfg_ff.volt_step};
         sec_pkg::REG_AMP_UPPER:  csr_prdata = {18'd0, cfg_ff.amp_upper};
         sec_pkg::REG_AMP_LOWER:  csr_prdata = {18'd0, cfg_ff.amp_lower};
         sec_pkg::REG_AMP_STEP:   csr_prdata = {22'd0, cfg_ff.amp_step};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volt_upper <= sec_pkg::VOLT_UPPER_RESET;
         cfg_ff.volt_lower <= sec_pkg::VOLT_LOWER_RESET;
         cfg_ff.volt_step  <= sec_pkg::VOLT_STEP_RESET;
         cfg_ff.amp_upper  <= sec_pkg::AMP_UPPER_RESET;
         cfg_ff.amp_lower  <= sec_pkg::AMP_LOWER_RESET;
         cfg_ff.amp_step   <= sec_pkg::AMP_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/sec_step.sv @@
`timescale 1ns / 1ps

module sec_step (
   input  sec_pkg::cfg_type   cfg,
   input  sec_pkg::state_type state,
   input  sec_pkg::item_type  item,
   output sec_pkg::state_type state_next,
   output sec_pkg::view_type  view
);

   always_comb begin
      sec_pkg::state_type                 nxt;
      sec_pkg::digit_type                 dg;
      logic                               is_digit;
      logic [1:0]                         sel;
      logic [sec_pkg::VALUE_W-1:0]        upper;
      logic [sec_pkg::VALUE_W-1:0]        lower;
      logic [sec_pkg::STEP_W-1:0]         step;
      logic [sec_pkg::VALUE_W+3:0]        acc_wide;
      logic [sec_pkg::VALUE_W-1:0]        cand;
      logic [sec_pkg::LEFT_W-1:0]         left_next;
      logic [sec_pkg::STAT_W-1:0]         fin_status;
      logic signed [sec_pkg::VALUE_W+1:0] enc_v;
      logic [sec_pkg::STAT_W-1:0]         status;
      logic [sec_pkg::VALUE_W-1:0]        shown;

      nxt      = state;
      dg       = sec_pkg::key_digit(item.key_code);
      is_digit = item.func && dg.hit;
      sel      = state.selection;
      upper    = sel[0] ? cfg.amp_upper : cfg.volt_upper;
      lower    = sel[0] ? cfg.amp_lower : cfg.volt_lower;
      step     = sel[0] ? cfg.amp_step  : cfg.volt_step;
      status   = sec_pkg::ST_NONE;
      shown    = '0;

      // A digit either extends the running entry or opens a new one.
      acc_wide = {4'd0, state.partial_number} * 18'd10 + {14'd0, dg.value};
      cand     = state.entering ? acc_wide[sec_pkg::VALUE_W-1:0]
                                : {10'd0, dg.value};
      if (state.entering) begin
         left_next = (state.digits_left != '0) ? state.digits_left - 3'd1 : '0;
      end else begin
         left_next = sec_pkg::entry_len(upper) - 3'd1;
      end

      // Below lower wins when both limits are violated.
      if (cand < lower) begin
         fin_status = sec_pkg::ST_LOWER;
      end else if (cand > upper) begin
         fin_status = sec_pkg::ST_UPPER;
      end else begin
         fin_status = sec_pkg::ST_ACCEPT;
      end

      // Lower clamp is applied last, so it wins over an inverted upper.
      enc_v = item.enc_up
            ? $signed({2'b00, state.setpoints[sel]}) + $signed({6'd0, step})
            : $signed({2'b00, state.setpoints[sel]}) - $signed({6'd0, step});
      if (enc_v > $signed({2'b00, upper})) begin
         enc_v = $signed({2'b00, upper});
      end
      if (enc_v < $signed({2'b00, lower})) begin
         enc_v = $signed({2'b00, lower});
      end

      if (state.entering && !is_digit) begin
         shown              = state.partial_number;
         status             = sec_pkg::ST_ABORT;
         nxt.entering       = 1'b0;
         nxt.digits_left    = '0;
         nxt.partial_number = '0;
      end else if (is_digit) begin
         shown = cand;
         if (left_next == '0) begin
            status = fin_status;
            if (fin_status == sec_pkg::ST_ACCEPT) begin
               nxt.setpoints[sel] = cand;
            end
            nxt.entering       = 1'b0;
            nxt.digits_left    = '0;
            nxt.partial_number = '0;
         end else begin
            status             = sec_pkg::ST_DIGIT;
            nxt.entering       = 1'b1;
            nxt.digits_left    = left_next;
            nxt.partial_number = cand;
         end
      end else if (!item.func) begin
         nxt.setpoints[sel] = enc_v[sec_pkg::VALUE_W-1:0];
      end else begin
         case (item.key_code)
            sec_pkg::KEY_SEL_CH1_VOLT: nxt.selection   = 2'd0;
            sec_pkg::KEY_SEL_CH1_AMP:  nxt.selection   = 2'd1;
            sec_pkg::KEY_SEL_CH2_VOLT: nxt.selection   = 2'd2;
            sec_pkg::KEY_SEL_CH2_AMP:  nxt.selection   = 2'd3;
            sec_pkg::KEY_OUTPUT:       nxt.enable_flag = !state.enable_flag;
            default: ;
         endcase
      end

      state_next          = nxt;
      view.selected_index = nxt.selection;
      view.setpoints      = nxt.setpoints;
      view.entry_active   = nxt.entering;
      view.entry_number   = shown;
      view.event_status   = status;
      view.output_on      = nxt.enable_flag;
   end

endmodule

@@ src/setpoint_entry_controller.sv @@
`timescale 1ns / 1ps

// Front-panel setpoint controller for a two-channel supply.
// Input items arrive on the req_ stream: tuser is the event kind (0 encoder
// detent, 1 key press), tdata carries the encoder direction and key number.
// Every item yields exactly one result item on the rsp_ stream with the
// selection, the four setpoints, the entry progress, the event status, the
// output enable and the channel-2 DAC code.
// Limits and step sizes are written through the csr_ APB port (byte address
// 4*i for register i); write them only while no item is in flight.
// The datapath is three registers deep: input register, state update into a
// middle register, DAC code into the result register. One item is taken
// every cycle while the result register is free or drained.
// The state update is a single pass of the step logic, so an item sees the
// state left by the previously accepted item.
// While a result waits with rsp_tready low the whole pipe holds and req_tready
// drops in the same cycle. Reset restores the limits, setpoints 5, 10, 5, 10,
// selection 0, output off, no entry in progress and an empty pipe.

module setpoint_entry_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // enc_up, key_code[4:0], zero fill
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // selected_index[1:0], ch1_volt, ch1_amp, ch2_volt, ch2_amp, entry_active,
   // entry_number, event_status[2:0], output_on, dac_code[11:0], zero fill
   output logic [95:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   sec_pkg::cfg_type   cfg;
   sec_pkg::state_type state_ff;
   sec_pkg::state_type state_in;
   sec_pkg::item_type  item_ff;
   sec_pkg::view_type  view_in;
   sec_pkg::view_type  mid_view_ff;
   sec_pkg::view_type  rsp_view_ff;
   logic                        in_valid_ff;
   logic                        mid_valid_ff;
   logic                        rsp_valid_ff;
   logic                        advance;
   logic                        update;
   logic [sec_pkg::DAC_W-1:0]   dac_in;
   logic [sec_pkg::DAC_W-1:0]   rsp_dac_ff;
   logic [sec_pkg::VALUE_W-1:0] ch2_volt;
   logic [sec_pkg::DAC_PROD_W-1:0] dac_prod;

   sec_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sec_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .view       (view_in)
   );

   // The pipe moves as one whenever the result register is free or drained.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign update     = advance && in_valid_ff;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;

   assign ch2_volt = mid_view_ff.setpoints[2];
   assign dac_prod = sec_pkg::DAC_PROD_W'(ch2_volt[sec_pkg::DAC_V_W-1:0])
                   * sec_pkg::DAC_PROD_W'(sec_pkg::DAC_MULT);

   always_comb begin
      if (!mid_view_ff.output_on) begin
         dac_in = '0;
      end else if (ch2_volt >= sec_pkg::VALUE_W'(sec_pkg::DAC_SAT_FROM)) begin
         dac_in = sec_pkg::DAC_MAX;
      end else begin
         dac_in = dac_prod[sec_pkg::DAC_FRAC +: sec_pkg::DAC_W]
                + sec_pkg::DAC_W'(sec_pkg::DAC_OFFSET);
      end
   end

   assign rsp_tdata = {7'd0,
                       rsp_dac_ff,
                       rsp_view_ff.output_on,
                       rsp_view_ff.event_status,
                       rsp_view_ff.entry_number,
                       rsp_view_ff.entry_active,
                       rsp_view_ff.setpoints[3],
                       rsp_view_ff.setpoints[2],
                       rsp_view_ff.setpoints[1],
                       rsp_view_ff.setpoints[0],
                       rsp_view_ff.selected_index};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff  <= req_tvalid;
         mid_valid_ff <= in_valid_ff;
         rsp_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.setpoints[0]   <= sec_pkg::VOLT_SETPOINT_RESET;
         state_ff.setpoints[1]   <= sec_pkg::AMP_SETPOINT_RESET;
         state_ff.setpoints[2]   <= sec_pkg::VOLT_SETPOINT_RESET;
         state_ff.setpoints[3]   <= sec_pkg::AMP_SETPOINT_RESET;
         state_ff.selection      <= 2'd0;
         state_ff.enable_flag    <= 1'b0;
         state_ff.entering       <= 1'b0;
         state_ff.partial_number <= '0;
         state_ff.digits_left    <= '0;
      end else if (update) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         item_ff.func     <= req_tuser;
         item_ff.enc_up   <= req_tdata[0];
         item_ff.key_code <= req_tdata[5:1];
      end
      if (update) begin
         mid_view_ff <= view_in;
      end
      if (advance && mid_valid_ff) begin
         rsp_view_ff <= mid_view_ff;
         rsp_dac_ff  <= dac_in;
      end
   end

   // An open entry always waits for at least one more digit.
   a_entry_has_digits: assert property (@(posedge clock) disable iff (reset)
      state_ff.entering |-> state_ff.digits_left != '0)
      else $error("entry open with no digits left");

   // The partial number is cleared whenever no entry is open.
   a_idle_partial_clear: assert property (@(posedge clock) disable iff (reset)
      !state_ff.entering |-> state_ff.partial_number == '0)
      else $error("partial number kept outside an entry");

   // Only an item passing the step logic changes the panel state.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !update |=> $stable(state_ff))
      else $error("state changed without an item");

   // A digit-taken status leaves the entry open; closing statuses do not.
   a_status_vs_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_view_ff.event_status == sec_pkg::ST_DIGIT)
                        == rsp_view_ff.entry_active))
      else $error("event status disagrees with entry state");

   // The DAC stays at zero while the output is off.
   a_dac_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_view_ff.output_on) |-> rsp_dac_ff == '0)
      else $error("DAC code nonzero with output off");

endmodule
